### rtl/assert_macros.svh
// Concurrent assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/ifl_pkg.sv
// Types and constants for the index allocator with free FIFO and bump counter
package ifl_pkg;

  localparam int IDX_W    = 10;
  localparam int CAP_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_RANGE_ERR  = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_BUMP = 2'd1,
    SEL_REL  = 2'd2,
    SEL_MEM  = 2'd3
  } out_sel_t;

  typedef struct packed {
    logic     pop;
    logic     push;
    logic     bump;
    logic     load_out;
    out_sel_t out_sel;
    status_t  status;
  } cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic queue_full;
    logic bump_room;
    logic rel_in_range;
  } stat_t;

endpackage

### rtl/ifl_ctrl.sv
// Controller: request decode, memory read wait state and output valid
module ifl_ctrl import ifl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  func,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '{pop: 1'b0, push: 1'b0, bump: 1'b0, load_out: 1'b0,
                   out_sel: SEL_ZERO, status: ST_OK};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_ALLOC) begin
            if (!stat.queue_empty) begin
              cmd.pop    = 1'b1;
              state_next = S_POP;
            end else if (stat.bump_room) begin
              cmd.bump     = 1'b1;
              cmd.load_out = 1'b1;
              cmd.out_sel  = SEL_BUMP;
            end else begin
              cmd.load_out = 1'b1;
              cmd.out_sel  = SEL_ZERO;
              cmd.status   = ST_NO_SPACE;
            end
          end else begin
            cmd.load_out = 1'b1;
            cmd.out_sel  = SEL_REL;
            if (!stat.rel_in_range) begin
              cmd.status = ST_RANGE_ERR;
            end else if (stat.queue_full) begin
              cmd.status = ST_QUEUE_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
        end
      end
      S_POP: begin
        cmd.load_out = 1'b1;
        cmd.out_sel  = SEL_MEM;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/ifl_dp.sv
// Datapath: free FIFO memory and pointers, bump counter, capacity and result word
module ifl_dp import ifl_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic [IDX_W-1:0]    release_index,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic [IDX_W-1:0]    slot_index,
  output logic [STATUS_W-1:0] status
);

  localparam int PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

  logic [IDX_W-1:0] mem [MAX_SLOTS];
  logic [IDX_W-1:0] rd_data;
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] bump_count;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] eff_cap;
  logic [IDX_W-1:0] slot_next;

  always_comb begin
    eff_cap = capacity;
    if (32'(capacity) > 32'(MAX_SLOTS)) begin
      eff_cap = CAP_W'(MAX_SLOTS);
    end
  end

  assign stat.queue_empty  = (count == '0);
  assign stat.queue_full   = (count == CNT_FULL);
  assign stat.bump_room    = (bump_count < eff_cap);
  assign stat.rel_in_range = (CAP_W'(release_index) < eff_cap);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= release_index;
    end
    if (cmd.pop) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      bump_count <= '0;
      capacity   <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.pop) begin
        head  <= (head == PTR_LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (cmd.push) begin
        tail  <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (cmd.bump) begin
        bump_count <= bump_count + 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.out_sel)
      SEL_ZERO: slot_next = '0;
      SEL_BUMP: slot_next = bump_count[IDX_W-1:0];
      SEL_REL:  slot_next = release_index;
      SEL_MEM:  slot_next = rd_data;
      default:  slot_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slot_index <= slot_next;
      status     <= cmd.status;
    end
  end

endmodule

### rtl/index_allocator_fifo_free_list_core.sv
// Top level of the slot index allocator with free FIFO and bump counter
// Each word on the input asks for a slot (func 0) or returns one (func 1) and
// produces one result word. Allocation reuses the oldest returned index from
// a MAX_SLOTS-deep free FIFO, otherwise takes the next fresh index from a bump
// counter, otherwise reports out of space. Release, fresh allocation and every
// error case are answered in the idle state; a free-FIFO allocation waits in a
// pop state for the registered read of the FIFO memory. A new word is taken
// only in a cycle in which the output register is empty or its result is
// taken, so a stalled output stalls the input. The input is not ready during
// reset. The FIFO memory needs no clearing after reset. capacity must be
// written through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce this. Values above MAX_SLOTS act as MAX_SLOTS.
module index_allocator_fifo_free_list_core import ifl_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [IDX_W-1:0]    release_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    slot_index,
  output logic [STATUS_W-1:0] status
);

`include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  ifl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ifl_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .release_index (release_index),
    .cmd           (cmd),
    .stat          (stat),
    .slot_index    (slot_index),
    .status        (status)
  );

  `ASSERT_IMPLIES(a_no_overrun, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, cmd.pop, !stat.queue_empty && !cmd.load_out)
  `ASSERT_IMPLIES(a_push_legal, clk, rst, cmd.push, stat.rel_in_range && !stat.queue_full)
  `ASSERT_NEXT(a_pop_fill, clk, rst, cmd.pop, cmd.load_out && (cmd.out_sel == SEL_MEM))

endmodule

### tb/tb_top.sv
// Self-checking testbench for the slot index allocator with free FIFO and bump counter
`timescale 1ns / 1ps

module tb_top import ifl_pkg::*;;

  localparam int MAX_SLOTS  = 1024;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic [IDX_W-1:0] slot;
    status_t          st;
  } slot_result_t;

  class alloc_scoreboard;
    logic [CAP_W-1:0] capacity;
    logic [IDX_W-1:0] free_fifo[$];
    int unsigned      bump_next;
    slot_result_t     expected_slots[$];
    int               errors;

    function new();
      capacity  = CAP_RESET;
      bump_next = 0;
      errors    = 0;
    endfunction

    function int unsigned eff_cap();
      return (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    task log_error(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Predict the result of one accepted request and queue it
    function void note_request(logic f, logic [IDX_W-1:0] idx);
      slot_result_t r;
      int unsigned cap;
      cap    = eff_cap();
      r.slot = '0;
      r.st   = ST_OK;
      if (f == FUNC_ALLOC) begin
        if (free_fifo.size() > 0) begin
          r.slot = free_fifo.pop_front();
        end else if (bump_next < cap) begin
          r.slot = bump_next[IDX_W-1:0];
          bump_next++;
        end else begin
          r.st = ST_NO_SPACE;
        end
      end else begin
        r.slot = idx;
        if (idx >= cap) begin
          r.st = ST_RANGE_ERR;
        end else if (free_fifo.size() >= MAX_SLOTS) begin
          r.st = ST_QUEUE_FULL;
        end else begin
          free_fifo.push_back(idx);
        end
      end
      expected_slots.push_back(r);
    endfunction

    task check_result(logic [IDX_W-1:0] slot, logic [STATUS_W-1:0] st);
      slot_result_t e;
      if (expected_slots.size() == 0) begin
        log_error($sformatf("unexpected word slot=%0d status=%0d", slot, st));
        return;
      end
      e = expected_slots.pop_front();
      if (slot !== e.slot)
        log_error($sformatf("slot_index got %0d exp %0d", slot, e.slot));
      if (st !== e.st)
        log_error($sformatf("status got %0d exp %0d (slot %0d)", st, e.st, e.slot));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CAP_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [IDX_W-1:0]    release_index;
  logic                out_valid;
  logic                out_ready;
  logic [IDX_W-1:0]    slot_index;
  logic [STATUS_W-1:0] status;

  alloc_scoreboard sb = new();
  bit  quiet_run;
  int  hold_left;
  int  cycle_count;

  index_allocator_fifo_free_list_core #(.MAX_SLOTS(MAX_SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .release_index (release_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_index    (slot_index),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(slot_index, status);
  end

  // Receiver: random back-pressure, quiet stretches, and a long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (quiet_run) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic send_word(logic f, logic [IDX_W-1:0] idx);
    if (!quiet_run && $urandom_range(0, 99) < 6) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    func          <= f;
    release_index <= idx;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_request(f, idx);
  endtask

  // Stop offering words and wait until every result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.capacity = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_run(int n, int alloc_pct);
    logic             f;
    logic [IDX_W-1:0] idx;
    int unsigned      cap;
    repeat (n) begin
      cap = sb.eff_cap();
      f   = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
      if (f == FUNC_RELEASE && cap > 0 && $urandom_range(0, 99) < 85)
        idx = IDX_W'($urandom_range(0, cap - 1));
      else
        idx = IDX_W'($urandom);
      send_word(f, idx);
    end
  endtask

  // Fill the free FIFO to the brim, then overflow it
  task automatic fill_free_list();
    while (sb.free_fifo.size() < MAX_SLOTS)
      send_word(FUNC_RELEASE, IDX_W'($urandom_range(0, MAX_SLOTS - 1)));
    repeat (3) send_word(FUNC_RELEASE, IDX_W'($urandom_range(0, MAX_SLOTS - 1)));
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    func          = FUNC_ALLOC;
    release_index = '0;
    quiet_run     = 1'b0;
    hold_left     = 0;
    cycle_count   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bump, reuse order, double release, edges of the index range
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_ALLOC, 10'd1023);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_RELEASE, 10'd2);
    send_word(FUNC_RELEASE, 10'd0);
    send_word(FUNC_RELEASE, 10'd0);
    send_word(FUNC_RELEASE, 10'd1023);
    repeat (5) send_word(FUNC_ALLOC, 10'd1023);
    set_capacity(11'd4);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_RELEASE, 10'd4);
    send_word(FUNC_RELEASE, 10'd3);
    send_word(FUNC_ALLOC, 10'd0);
    set_capacity(11'd0);
    send_word(FUNC_RELEASE, 10'd0);
    send_word(FUNC_ALLOC, 10'd0);
    set_capacity(11'd2047);
    send_word(FUNC_RELEASE, 10'd1023);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_RELEASE, 10'd1000);
    // lowered capacity still hands out what is queued
    set_capacity(11'd1);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_ALLOC, 10'd0);
    send_word(FUNC_RELEASE, 10'd1);
    send_word(FUNC_RELEASE, 10'd0);
    send_word(FUNC_ALLOC, 10'd0);

    // random
    set_capacity(11'd1024);
    quiet_run = 1'b1;
    random_run(150, 50);
    quiet_run = 1'b0;
    set_capacity(11'd2);
    random_run(40, 50);
    set_capacity(11'd2047);
    hold_left = HOLD_LEN;
    random_run(60, 45);
    settle();
    random_run(30, 45);
    set_capacity(11'd0);
    random_run(20, 50);
    set_capacity(CAP_W'($urandom_range(3, 1023)));
    random_run(50, 55);
    set_capacity(11'd1);
    random_run(20, 50);
    set_capacity(11'd1024);
    fill_free_list();
    set_capacity(CAP_W'($urandom_range(1025, 2047)));
    hold_left = HOLD_LEN;
    random_run(30, 50);
    set_capacity(CAP_W'($urandom_range(1, 1024)));
    random_run(30, 50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
